// ===== hdl/lcd_pkg.sv =====
// Shared types and constants of the four-channel load contact detector.
// Depends on nothing; the top level imports it.
`default_nettype none

package lcd_pkg;

  localparam int NUM_CH   = 4;
  localparam int SAMPLE_W = 24;
  localparam int SUM_W    = 32;
  localparam int CNT_W    = 8;
  localparam int THR_W    = 23;
  localparam int HYS_W    = 22;
  localparam int CFG_W    = 23;
  localparam int CFG_IDX_W = 1;

  // Rounds of the tare phase (1 to 255); also the divisor of the tare sums.
  localparam int TARE_ROUNDS = 50;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(25000);
  localparam logic [HYS_W-1:0] HYS_RESET = HYS_W'(5000);

  // Division of a sum magnitude by TARE_ROUNDS through a reciprocal multiply.
  // With the shift below, the rounded-up reciprocal gives exact floor division
  // for every magnitude below 2**MAG_W.
  localparam int MAG_W     = SUM_W - 1;
  localparam int MULT_W    = MAG_W + 1;
  localparam int PROD_W    = MAG_W + MULT_W;
  localparam int DIV_SHIFT = MAG_W + $clog2(TARE_ROUNDS);
  localparam longint unsigned DIV_MULT_L =
      ((longint'(1) << DIV_SHIFT) + longint'(TARE_ROUNDS) - 1) / longint'(TARE_ROUNDS);
  localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(DIV_MULT_L);

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_RETARE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD  = 1'b0,
    CFG_HYSTERESIS = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_MAG,
    DIV_MUL,
    DIV_LOAD
  } div_state_t;

  typedef struct packed {
    logic mag_en;
    logic mul_en;
    logic load_en;
  } div_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/load_contact_detector_with_autotare.sv =====
// Four-channel load contact detector with automatic tare and hysteresis.
// Depends on lcd_pkg (widths, reset values, divider constants, state codes).
//
//   channel   direction  handshake            payload
//   in_       in         in_valid / in_stall  command, valid_k, sample_k
//   out_      out        out_valid / out_stall tare_busy, ground_k, distance_k
//   cfg_      in         cfg_we               cfg_index, cfg_wdata
//
// An item passes from the input register into the result register; one item per
// cycle is accepted and delivered while the output is not stalled and no divide runs.
// On the round that ends the tare phase the zero levels are computed by a reciprocal
// multiply (magnitude, multiply, signed load steps), during which the next item waits.
// Reset (rst_n low, synchronous) restores register defaults and starts the tare.
// A stalled result holds while one further beat can still enter the input register.
`default_nettype none

module load_contact_detector_with_autotare
  import lcd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_wdata,

  input  wire logic                   in_valid,
  output      logic                   in_stall,
  input  wire logic                   in_command,
  input  wire logic                   in_valid_0,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_0,
  input  wire logic                   in_valid_1,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_1,
  input  wire logic                   in_valid_2,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_2,
  input  wire logic                   in_valid_3,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_3,

  output      logic                   out_valid,
  input  wire logic                   out_stall,
  output      logic                   out_tare_busy,
  output      logic                   out_ground_0,
  output      logic                   out_ground_1,
  output      logic                   out_ground_2,
  output      logic                   out_ground_3,
  output      logic [SAMPLE_W-1:0]    out_distance_0,
  output      logic [SAMPLE_W-1:0]    out_distance_1,
  output      logic [SAMPLE_W-1:0]    out_distance_2,
  output      logic [SAMPLE_W-1:0]    out_distance_3
);

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int CMP_W  = SAMPLE_W + 2;

  // Configuration registers.
  logic [THR_W-1:0] thr_r;
  logic [HYS_W-1:0] hys_r;

  // Input register.
  logic                       s0_valid_r;
  logic                       s0_cmd_r;
  logic [NUM_CH-1:0]          s0_vld_r;
  logic signed [SAMPLE_W-1:0] s0_smp_r [NUM_CH];

  // Detector state.
  logic signed [SUM_W-1:0]    tare_sum_r  [NUM_CH];
  logic signed [SUM_W-1:0]    tare_sum_nxt[NUM_CH];
  logic signed [SAMPLE_W-1:0] zero_r      [NUM_CH];
  logic [CNT_W-1:0]           tare_cnt_r, tare_cnt_nxt;
  logic                       tare_r, tare_nxt;
  logic [NUM_CH-1:0]          ground_r, ground_nxt;

  // Zero-level divider.
  div_state_t        div_state_r, div_state_nxt;
  div_ctrl_t         div_ctrl;
  logic [MAG_W-1:0]  mag_r  [NUM_CH];
  logic [NUM_CH-1:0] neg_r;
  logic [NUM_CH-1:0] neg_mul_r;
  logic [PROD_W-1:0] prod_r [NUM_CH];
  logic              start_div;

  // Result register.
  logic                out_valid_r;
  logic                busy_r, busy_nxt;
  logic [NUM_CH-1:0]   out_ground_r;
  logic [SAMPLE_W-1:0] dist_r  [NUM_CH];
  logic [SAMPLE_W-1:0] dist_nxt[NUM_CH];

  logic advance;
  logic proc;
  logic in_accept;

  logic signed [CMP_W-1:0] set_bound;
  logic signed [CMP_W-1:0] clr_bound;

  logic signed [DIFF_W-1:0] diff   [NUM_CH];
  logic        [DIFF_W-1:0] absd   [NUM_CH];
  logic [CNT_W-1:0]         cnt_inc;

  assign advance   = !out_valid_r || !out_stall;
  assign proc      = s0_valid_r && advance && (div_state_r == DIV_IDLE);
  assign in_stall  = s0_valid_r && !proc;
  assign in_accept = in_valid && !in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      hys_r <= HYS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:  thr_r <= cfg_wdata[THR_W-1:0];
        CFG_HYSTERESIS: hys_r <= cfg_wdata[HYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_accept) begin
      s0_valid_r <= 1'b1;
    end else if (proc) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s0_cmd_r    <= in_command;
      s0_vld_r    <= {in_valid_3, in_valid_2, in_valid_1, in_valid_0};
      s0_smp_r[0] <= in_sample_0;
      s0_smp_r[1] <= in_sample_1;
      s0_smp_r[2] <= in_sample_2;
      s0_smp_r[3] <= in_sample_3;
    end
  end

  // Both bounds fit a signed word two bits wider than a sample, so nothing wraps.
  assign set_bound = CMP_W'(thr_r) + CMP_W'(hys_r);
  assign clr_bound = CMP_W'(thr_r) - CMP_W'(hys_r);
  assign cnt_inc   = tare_cnt_r + 1'b1;

  always_comb begin
    tare_cnt_nxt = tare_cnt_r;
    tare_nxt     = tare_r;
    ground_nxt   = ground_r;
    start_div    = 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      tare_sum_nxt[i] = tare_sum_r[i];
      dist_nxt[i]     = '0;
      diff[i]         = DIFF_W'(s0_smp_r[i]) - DIFF_W'(zero_r[i]);
      absd[i]         = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
    end

    if (s0_cmd_r == CMD_RETARE) begin
      for (int i = 0; i < NUM_CH; i++) begin
        tare_sum_nxt[i] = '0;
      end
      tare_cnt_nxt = '0;
      tare_nxt     = 1'b1;
    end else if (tare_r) begin
      for (int i = 0; i < NUM_CH; i++) begin
        if (s0_vld_r[i]) begin
          tare_sum_nxt[i] = tare_sum_r[i] + SUM_W'(s0_smp_r[i]);
        end
      end
      tare_cnt_nxt = cnt_inc;
      if (cnt_inc >= CNT_W'(TARE_ROUNDS)) begin
        tare_nxt  = 1'b0;
        start_div = 1'b1;
      end
    end else begin
      for (int i = 0; i < NUM_CH; i++) begin
        if (s0_vld_r[i]) begin
          dist_nxt[i] = absd[i][SAMPLE_W-1:0];
          if (ground_r[i]) begin
            if ($signed({1'b0, absd[i]}) < clr_bound) begin
              ground_nxt[i] = 1'b0;
            end
          end else begin
            if ($signed({1'b0, absd[i]}) > set_bound) begin
              ground_nxt[i] = 1'b1;
            end
          end
        end
      end
    end
    busy_nxt = tare_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tare_cnt_r <= '0;
      tare_r     <= 1'b1;
      ground_r   <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        tare_sum_r[i] <= '0;
      end
    end else if (proc) begin
      tare_cnt_r <= tare_cnt_nxt;
      tare_r     <= tare_nxt;
      ground_r   <= ground_nxt;
      for (int i = 0; i < NUM_CH; i++) begin
        tare_sum_r[i] <= tare_sum_nxt[i];
      end
    end
  end

  // Divider sequencer: magnitude, reciprocal multiply, signed load.
  always_comb begin
    div_state_nxt = div_state_r;
    case (div_state_r)
      DIV_IDLE: begin
        if (proc && start_div) begin
          div_state_nxt = DIV_MAG;
        end
      end
      DIV_MAG:  div_state_nxt = DIV_MUL;
      DIV_MUL:  div_state_nxt = DIV_LOAD;
      DIV_LOAD: div_state_nxt = DIV_IDLE;
      default:  div_state_nxt = DIV_IDLE;
    endcase
  end

  always_comb begin
    div_ctrl = '0;
    case (div_state_r)
      DIV_MAG:  div_ctrl.mag_en  = 1'b1;
      DIV_MUL:  div_ctrl.mul_en  = 1'b1;
      DIV_LOAD: div_ctrl.load_en = 1'b1;
      default:  div_ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_state_r <= DIV_IDLE;
    end else begin
      div_state_r <= div_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CH; i++) begin
      if (div_ctrl.mag_en) begin
        neg_r[i] <= tare_sum_r[i][SUM_W-1];
        mag_r[i] <= tare_sum_r[i][SUM_W-1] ? MAG_W'(-tare_sum_r[i]) : MAG_W'(tare_sum_r[i]);
      end
      if (div_ctrl.mul_en) begin
        neg_mul_r[i] <= neg_r[i];
        prod_r[i]    <= PROD_W'(mag_r[i]) * PROD_W'(DIV_MULT);
      end
    end
  end

  // Truncation toward zero: divide the magnitude, then restore the sign.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        zero_r[i] <= '0;
      end
    end else if (div_ctrl.load_en) begin
      for (int i = 0; i < NUM_CH; i++) begin
        zero_r[i] <= neg_mul_r[i] ? -prod_r[i][DIV_SHIFT +: SAMPLE_W]
                                  : prod_r[i][DIV_SHIFT +: SAMPLE_W];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      busy_r       <= busy_nxt;
      out_ground_r <= ground_nxt;
      for (int i = 0; i < NUM_CH; i++) begin
        dist_r[i] <= dist_nxt[i];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tare_busy  = busy_r;
  assign out_ground_0   = out_ground_r[0];
  assign out_ground_1   = out_ground_r[1];
  assign out_ground_2   = out_ground_r[2];
  assign out_ground_3   = out_ground_r[3];
  assign out_distance_0 = dist_r[0];
  assign out_distance_1 = dist_r[1];
  assign out_distance_2 = dist_r[2];
  assign out_distance_3 = dist_r[3];

endmodule

`default_nettype wire

// ===== verif/tb_load_contact_detector_with_autotare.sv =====
// Self-checking testbench for the four-channel load contact detector with auto-tare.
// Depends on lcd_pkg and load_contact_detector_with_autotare; a built-in predictor
// computes every result beat, and a monitor compares the beats field by field.
`timescale 1ns / 1ps

module tb_load_contact_detector_with_autotare
  import lcd_pkg::*;
();

  localparam int     CYCLE_LIMIT = 300000;
  localparam longint SMP_MAX     = 8388607;
  localparam longint SMP_MIN     = -8388608;

  typedef struct packed {
    cmd_t                              command;
    logic [NUM_CH-1:0]                 vld;
    logic [NUM_CH-1:0][SAMPLE_W-1:0]   smp;
  } round_t;

  typedef struct packed {
    logic                              busy;
    logic [NUM_CH-1:0]                 gnd;
    logic [NUM_CH-1:0][SAMPLE_W-1:0]   distance;
  } status_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_command = 1'b0;
  logic                   in_valid_0 = 1'b0;
  logic                   in_valid_1 = 1'b0;
  logic                   in_valid_2 = 1'b0;
  logic                   in_valid_3 = 1'b0;
  logic [SAMPLE_W-1:0]    in_sample_0 = '0;
  logic [SAMPLE_W-1:0]    in_sample_1 = '0;
  logic [SAMPLE_W-1:0]    in_sample_2 = '0;
  logic [SAMPLE_W-1:0]    in_sample_3 = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_tare_busy;
  logic                   out_ground_0;
  logic                   out_ground_1;
  logic                   out_ground_2;
  logic                   out_ground_3;
  logic [SAMPLE_W-1:0]    out_distance_0;
  logic [SAMPLE_W-1:0]    out_distance_1;
  logic [SAMPLE_W-1:0]    out_distance_2;
  logic [SAMPLE_W-1:0]    out_distance_3;

  // Predictor state, mirroring the detector after each accepted round.
  logic [THR_W-1:0]  band_center = THR_RESET;
  logic [HYS_W-1:0]  band_half = HYS_RESET;
  longint            zero_lvl [NUM_CH] = '{default: 0};
  longint            tare_acc [NUM_CH] = '{default: 0};
  logic [CNT_W-1:0]  tare_rounds_seen = '0;
  logic              taring = 1'b1;
  logic [NUM_CH-1:0] on_ground = '0;

  status_t pending_status [$];
  int      mismatches = 0;
  int      cycle_count = 0;
  int      tx_idle_pct = 18;
  int      rx_hold_pct = 78;

  load_contact_detector_with_autotare uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_valid_0     (in_valid_0),
    .in_sample_0    (in_sample_0),
    .in_valid_1     (in_valid_1),
    .in_sample_1    (in_sample_1),
    .in_valid_2     (in_valid_2),
    .in_sample_2    (in_sample_2),
    .in_valid_3     (in_valid_3),
    .in_sample_3    (in_sample_3),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tare_busy  (out_tare_busy),
    .out_ground_0   (out_ground_0),
    .out_ground_1   (out_ground_1),
    .out_ground_2   (out_ground_2),
    .out_ground_3   (out_ground_3),
    .out_distance_0 (out_distance_0),
    .out_distance_1 (out_distance_1),
    .out_distance_2 (out_distance_2),
    .out_distance_3 (out_distance_3)
  );

  always #2 clk = ~clk;

  function automatic status_t predict_round(round_t r);
    status_t s;
    longint  dev;
    longint  set_lvl;
    longint  clr_lvl;
    s = '0;
    if (r.command == CMD_RETARE) begin
      for (int k = 0; k < NUM_CH; k++) tare_acc[k] = 0;
      tare_rounds_seen = '0;
      taring = 1'b1;
    end else if (taring) begin
      for (int k = 0; k < NUM_CH; k++) begin
        if (r.vld[k]) tare_acc[k] += longint'($signed(r.smp[k]));
      end
      tare_rounds_seen = tare_rounds_seen + 1'b1;
      if (tare_rounds_seen >= TARE_ROUNDS) begin
        // Signed division truncates toward zero, as the tare requires.
        for (int k = 0; k < NUM_CH; k++) zero_lvl[k] = tare_acc[k] / longint'(TARE_ROUNDS);
        taring = 1'b0;
      end
    end else begin
      set_lvl = longint'(band_center) + longint'(band_half);
      clr_lvl = longint'(band_center) - longint'(band_half);
      for (int k = 0; k < NUM_CH; k++) begin
        if (r.vld[k]) begin
          dev = longint'($signed(r.smp[k])) - zero_lvl[k];
          if (dev < 0) dev = -dev;
          s.distance[k] = dev[SAMPLE_W-1:0];
          if (on_ground[k]) begin
            if (dev < clr_lvl) on_ground[k] = 1'b0;
          end else if (dev > set_lvl) begin
            on_ground[k] = 1'b1;
          end
        end
      end
    end
    s.busy = taring;
    s.gnd  = on_ground;
    return s;
  endfunction

  function automatic round_t make_round(cmd_t c, logic [NUM_CH-1:0] v,
                                        logic [SAMPLE_W-1:0] s0, logic [SAMPLE_W-1:0] s1,
                                        logic [SAMPLE_W-1:0] s2, logic [SAMPLE_W-1:0] s3);
    round_t r;
    r.command = c;
    r.vld     = v;
    r.smp     = {s3, s2, s1, s0};
    return r;
  endfunction

  // Sample at a given signed offset from a channel's zero level, saturated to 24 bits.
  function automatic logic [SAMPLE_W-1:0] near_zero(int k, longint dev);
    longint s;
    s = zero_lvl[k] + dev;
    if (s > SMP_MAX) s = SMP_MAX;
    else if (s < SMP_MIN) s = SMP_MIN;
    return s[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample(int k);
    longint mag;
    case ($urandom_range(9))
      0, 1, 2: return SAMPLE_W'($urandom);
      3, 4, 5: begin
        // Just around either edge of the contact band.
        mag = longint'(band_center) + ($urandom_range(1) ? longint'(band_half)
                                                         : -longint'(band_half));
        mag = mag + longint'($urandom_range(0, 6)) - 3;
        if ($urandom_range(1)) mag = -mag;
        return near_zero(k, mag);
      end
      default: return near_zero(k, longint'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  task automatic send_round(round_t r);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= r.command;
    in_valid_0  <= r.vld[0];
    in_valid_1  <= r.vld[1];
    in_valid_2  <= r.vld[2];
    in_valid_3  <= r.vld[3];
    in_sample_0 <= r.smp[0];
    in_sample_1 <= r.smp[1];
    in_sample_2 <= r.smp[2];
    in_sample_3 <= r.smp[3];
    do @(posedge clk); while (in_stall);
    pending_status.push_back(predict_round(r));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(cfg_index_t idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_THRESHOLD) band_center = data[THR_W-1:0];
    else band_half = data[HYS_W-1:0];
  endtask

  task automatic randomize_band();
    logic [CFG_W-1:0] t;
    logic [CFG_W-1:0] h;
    case ($urandom_range(5))
      0:       t = '0;
      1:       t = CFG_W'(SMP_MAX);
      default: t = CFG_W'($urandom_range(0, 60000));
    endcase
    // Bit 22 of the hysteresis write is above the register and must be dropped.
    case ($urandom_range(5))
      0:       h = '0;
      1:       h = '1;
      default: h = CFG_W'($urandom_range(0, 20000)) | (CFG_W'($urandom_range(1)) << HYS_W);
    endcase
    write_config(CFG_THRESHOLD, t);
    write_config(CFG_HYSTERESIS, h);
  endtask

  // Tare with the sample extremes, a channel that never reads, and a channel
  // whose negative mean must truncate toward zero.
  task automatic test_tare_extremes();
    for (int i = 0; i < TARE_ROUNDS; i++) begin
      send_round(make_round(CMD_SAMPLE, {1'b0, i[0], 2'b11},
                            24'h7FFFFF, 24'h800000, SAMPLE_W'(i[0] ? -3 : -4),
                            SAMPLE_W'($urandom)));
    end
  endtask

  task automatic test_distance_extremes();
    send_round(make_round(CMD_SAMPLE, 4'b1111, 24'h800000, 24'h7FFFFF, SAMPLE_W'(-1),
                          SAMPLE_W'(30000)));
    send_round(make_round(CMD_SAMPLE, 4'b1000, '0, '0, '0, SAMPLE_W'(30001)));
    send_round(make_round(CMD_SAMPLE, 4'b1000, '0, '0, '0, SAMPLE_W'(20000)));
    send_round(make_round(CMD_SAMPLE, 4'b0000, '0, '0, '0, '0));
    send_round(make_round(CMD_SAMPLE, 4'b1000, '0, '0, '0, SAMPLE_W'(19999)));
    send_round(make_round(CMD_SAMPLE, 4'b1000, '0, '0, '0, SAMPLE_W'(-30001)));
    send_round(make_round(CMD_SAMPLE, 4'b1011, 24'h7FFFFF, 24'h800000, '0,
                          SAMPLE_W'(-19999)));
  endtask

  // Retare while flags are set and again in mid-tare; flags must hold throughout.
  task automatic test_retare_holds();
    round_t r;
    send_round(make_round(CMD_SAMPLE, 4'b0011, near_zero(0, -30001), near_zero(1, 30001),
                          '0, '0));
    send_round(make_round(CMD_RETARE, 4'b1111, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                          SAMPLE_W'($urandom), SAMPLE_W'($urandom)));
    for (int i = 0; i < TARE_ROUNDS + 10; i++) begin
      r.command = (i == 10) ? CMD_RETARE : CMD_SAMPLE;
      for (int k = 0; k < NUM_CH; k++) begin
        r.vld[k] = ($urandom_range(99) < 80);
        r.smp[k] = SAMPLE_W'(longint'($urandom_range(0, 200000)) - 100000);
      end
      send_round(r);
    end
    send_round(make_round(CMD_SAMPLE, 4'b1111, near_zero(0, 0), near_zero(1, 0),
                          near_zero(2, 0), near_zero(3, 0)));
  endtask

  task automatic test_config_extremes();
    drain_results();
    // Band below zero: a set flag never clears.
    write_config(CFG_THRESHOLD, '0);
    write_config(CFG_HYSTERESIS, '1);
    send_round(make_round(CMD_SAMPLE, 4'b1111, near_zero(0, 4194303), near_zero(1, 4194304),
                          near_zero(2, -4194304), near_zero(3, 0)));
    send_round(make_round(CMD_SAMPLE, 4'b1111, near_zero(0, 0), near_zero(1, 0),
                          near_zero(2, 0), near_zero(3, 0)));
    drain_results();
    write_config(CFG_THRESHOLD, CFG_W'(SMP_MAX));
    write_config(CFG_HYSTERESIS, '0);
    send_round(make_round(CMD_SAMPLE, 4'b1111, near_zero(0, SMP_MAX), near_zero(1, SMP_MAX),
                          near_zero(2, -8388606), near_zero(3, SMP_MIN)));
    send_round(make_round(CMD_SAMPLE, 4'b1111, near_zero(0, SMP_MAX), near_zero(1, 8388606),
                          near_zero(2, 0), near_zero(3, SMP_MAX)));
    drain_results();
    write_config(CFG_THRESHOLD, CFG_W'(THR_RESET));
    write_config(CFG_HYSTERESIS, CFG_W'(HYS_RESET));
  endtask

  task automatic test_random_rounds(int tx_pct, int rx_pct);
    round_t r;
    drain_results();
    tx_idle_pct = tx_pct;
    rx_hold_pct = rx_pct;
    for (int blk = 0; blk < 3; blk++) begin
      drain_results();
      randomize_band();
      for (int n = 0; n < 90; n++) begin
        r.command = ($urandom_range(199) == 0) ? CMD_RETARE : CMD_SAMPLE;
        for (int k = 0; k < NUM_CH; k++) begin
          r.vld[k] = ($urandom_range(99) < 85);
          r.smp[k] = random_sample(k);
        end
        send_round(r);
      end
    end
  endtask

  task automatic compare_field(string name, logic [SAMPLE_W-1:0] want,
                               logic [SAMPLE_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    status_t want;
    status_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.busy     = out_tare_busy;
      got.gnd      = {out_ground_3, out_ground_2, out_ground_1, out_ground_0};
      got.distance = {out_distance_3, out_distance_2, out_distance_1, out_distance_0};
      if (pending_status.size() == 0) begin
        $error("result beat with no round outstanding");
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        compare_field("tare_busy", SAMPLE_W'(want.busy), SAMPLE_W'(got.busy));
        for (int k = 0; k < NUM_CH; k++) begin
          compare_field($sformatf("ground_%0d", k), SAMPLE_W'(want.gnd[k]),
                        SAMPLE_W'(got.gnd[k]));
          compare_field($sformatf("distance_%0d", k), want.distance[k], got.distance[k]);
        end
      end
    end
    out_stall <= ($urandom_range(99) < rx_hold_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("load_contact_detector_with_autotare: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_tare_extremes();
    test_distance_extremes();
    test_retare_holds();
    test_config_extremes();
    test_random_rounds(18, 78);
    test_random_rounds(78, 18);
    test_random_rounds(0, 0);
    drain_results();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("load_contact_detector_with_autotare: match");
    end else begin
      $display("load_contact_detector_with_autotare: mismatch");
    end
    $finish;
  end

endmodule
